[design/tor_pkg.sv]
// package for the telnet option responder: byte codes, phase and descriptor types
// and the terminal-type reply table; no dependencies
`timescale 1ns / 1ps

package tor_pkg;

	localparam logic [7:0] ByteIac  = 8'd255;
	localparam logic [7:0] ByteDont = 8'd254;
	localparam logic [7:0] ByteDo   = 8'd253;
	localparam logic [7:0] ByteWont = 8'd252;
	localparam logic [7:0] ByteWill = 8'd251;
	localparam logic [7:0] ByteSb   = 8'd250;
	localparam logic [7:0] ByteSe   = 8'd240;

	localparam logic [7:0] OptEcho     = 8'd1;
	localparam logic [7:0] OptSuppress = 8'd3;
	localparam logic [7:0] OptTtype    = 8'd24;

	// default depth of the action queue between parser and emitter
	localparam int QueueDepth = 4;

	// reply byte index, wide enough for the ten-byte terminal-type reply
	localparam int IdxW = 4;
	localparam logic [IdxW-1:0] TripleLastIdx = IdxW'(2);
	localparam logic [IdxW-1:0] TtypeLastIdx  = IdxW'(9);

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CMD,
		PH_OPT,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		ACT_TERM,
		ACT_TRIPLE,
		ACT_TTYPE
	} act_kind_t;

	// one queued action: what the emitter must send
	typedef struct packed {
		act_kind_t  kind;
		logic [7:0] verb;
		logic [7:0] arg;
	} act_t;

	function automatic logic [7:0] ttype_byte(input logic [IdxW-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = ByteIac;
			4'd1:    b = ByteSb;
			4'd2:    b = OptTtype;
			4'd3:    b = 8'd0;
			4'd4:    b = 8'd65;
			4'd5:    b = 8'd78;
			4'd6:    b = 8'd83;
			4'd7:    b = 8'd73;
			4'd8:    b = ByteIac;
			4'd9:    b = ByteSe;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

[design/tor_if.sv]
// valid/ready channel interfaces for received bytes and emitted bytes
// depends on nothing
`timescale 1ns / 1ps

interface tor_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tor_out_if;
	logic       valid;
	logic       ready;
	logic       dest;
	logic [7:0] data;
	logic       last;

	modport source (output valid, output dest, output data, output last, input ready);
	modport sink (input valid, input dest, input data, input last, output ready);
endinterface

[design/tor_front.sv]
// front end: telnet command parser that turns received bytes into queued actions
// depends on tor_pkg
`timescale 1ns / 1ps

module tor_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic [7:0]    rx_byte,
	output logic          push,
	output tor_pkg::act_t act
);
	import tor_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [7:0] held_command_q;
	logic       is_will_wont;

	assign is_will_wont = (held_command_q == ByteWill) || (held_command_q == ByteWont);

	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_DATA: begin
				if (rx_byte == ByteIac) phase_nxt = PH_CMD;
			end
			PH_CMD: phase_nxt = PH_OPT;
			PH_OPT: begin
				if (held_command_q == ByteSb && rx_byte != ByteSe) phase_nxt = PH_SKIP;
				else phase_nxt = PH_DATA;
			end
			PH_SKIP: begin
				if (rx_byte == ByteSe) phase_nxt = PH_DATA;
			end
			default: phase_nxt = PH_DATA;
		endcase
	end

	always_comb begin
		push     = 1'b0;
		act.kind = ACT_TERM;
		act.verb = ByteIac;
		act.arg  = rx_byte;
		unique case (phase_q)
			PH_DATA: push = in_fire && (rx_byte != ByteIac);
			PH_CMD:  push = 1'b0;
			PH_OPT: begin
				act.kind = ACT_TRIPLE;
				priority if (held_command_q == ByteDo &&
						(rx_byte == OptSuppress || rx_byte == OptTtype)) begin
					push     = in_fire;
					act.verb = ByteWill;
				end else if (is_will_wont && (rx_byte == OptEcho ||
						rx_byte == OptSuppress || rx_byte == OptTtype)) begin
					push     = in_fire;
					act.verb = ByteDo;
				end else if (is_will_wont) begin
					push     = in_fire;
					act.verb = ByteDont;
				end else if (held_command_q == ByteDo || held_command_q == ByteDont) begin
					push     = in_fire;
					act.verb = ByteWont;
				end else if (held_command_q == ByteSb && rx_byte == ByteSe) begin
					push     = in_fire;
					act.kind = ACT_TTYPE;
				end else begin
					push = 1'b0;
				end
			end
			PH_SKIP: begin
				act.kind = ACT_TTYPE;
				push     = in_fire && (rx_byte == ByteSe);
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_DATA;
			held_command_q <= 8'd0;
		end else if (in_fire) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_CMD) held_command_q <= rx_byte;
		end
	end

endmodule

[design/tor_queue.sv]
// small register queue of actions between parser and emitter
// depends on tor_pkg
`timescale 1ns / 1ps

module tor_queue #(
	parameter int DEPTH = tor_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tor_pkg::act_t push_act,
	input  logic          pop,
	output tor_pkg::act_t head,
	output logic          empty,
	output logic          full
);
	import tor_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	act_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign empty   = (count_q == CntW'(0));
	assign full    = (count_q == CntW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CntW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
		end
	end

endmodule

[design/tor_back.sv]
// back end: expands queued actions into output bytes through an output register
// depends on tor_pkg
`timescale 1ns / 1ps

module tor_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tor_pkg::act_t head,
	input  logic          empty,
	output logic          pop,
	tor_out_if.source     tx
);
	import tor_pkg::*;

	logic [IdxW-1:0] idx_q;
	logic            out_valid_q;
	logic            out_dest_q;
	logic [7:0]      out_data_q;
	logic            out_last_q;
	logic            load;
	logic            byte_dest;
	logic [7:0]      byte_data;
	logic            byte_last;

	assign load = !empty && (!out_valid_q || tx.ready);
	assign pop  = load && byte_last;

	always_comb begin
		unique case (head.kind)
			ACT_TERM: begin
				byte_dest = 1'b0;
				byte_data = head.arg;
				byte_last = 1'b1;
			end
			ACT_TRIPLE: begin
				byte_dest = 1'b1;
				byte_last = (idx_q == TripleLastIdx);
				if (idx_q == IdxW'(0)) byte_data = ByteIac;
				else if (idx_q == IdxW'(1)) byte_data = head.verb;
				else byte_data = head.arg;
			end
			ACT_TTYPE: begin
				byte_dest = 1'b1;
				byte_data = ttype_byte(idx_q);
				byte_last = (idx_q == TtypeLastIdx);
			end
			default: begin
				byte_dest = 1'b1;
				byte_data = 8'd0;
				byte_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= byte_last ? '0 : idx_q + IdxW'(1);
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_dest_q <= byte_dest;
			out_data_q <= byte_data;
			out_last_q <= byte_last;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.dest  = out_dest_q;
	assign tx.data  = out_data_q;
	assign tx.last  = out_last_q;

endmodule

[design/telnet_option_responder_core.sv]
// Telnet option responder. Bytes from the server arrive on rx, one transaction each;
// results leave on tx as bytes tagged with dest (0 = local terminal, 1 = network reply)
// and last, which marks the final byte that one received byte causes. A parser in front
// tracks the IAC / command / option / subnegotiation-skip phase and pushes one action
// per reply into a small queue (QUEUE_DEPTH entries); an emitter behind it expands each
// action through an output register: a terminal byte is one output byte, a WILL/DO/DONT/
// WONT reply is three (IAC verb option), the terminal-type reply is ten. Plain data flows
// at one byte per cycle in and out while tx is ready. Replies occupy the emitter for
// three or ten output bytes, so rx stalls only once the queue has filled behind them;
// rx.ready is simply "queue not full". Commands other than WILL, WONT, DO, DONT and SB
// take their option byte and are dropped; inside a subnegotiation every byte is compared
// raw against SE. Depends on tor_pkg, tor_if, tor_front, tor_queue and tor_back.
`timescale 1ns / 1ps

module telnet_option_responder_core #(
	parameter int QUEUE_DEPTH = tor_pkg::QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	tor_in_if.sink    rx,
	tor_out_if.source tx
);
	import tor_pkg::*;

	logic in_fire;
	logic push;
	act_t push_act;
	logic pop;
	act_t head;
	logic empty;
	logic full;

	// input side only waits for space in the action queue
	assign rx.ready = !full;
	assign in_fire  = rx.valid && !full;

	// parser: phase tracking and reply classification
	tor_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (rx.rx_byte),
		.push    (push),
		.act     (push_act)
	);

	// decouples parsing from reply emission
	tor_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_act (push_act),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// emitter: one output byte per cycle from the head action while tx is ready
	tor_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

[design/tor_checker.sv]
// port-level checks for the telnet option responder, bound to the top level
// depends on tor_pkg and tor_if
`timescale 1ns / 1ps

module tor_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic       tx_dest,
	input logic [7:0] tx_data,
	input logic       tx_last
);
	import tor_pkg::*;

	logic mid_reply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_reply_q <= 1'b0;
		end else if (tx_valid && tx_ready) begin
			mid_reply_q <= tx_dest && !tx_last;
		end
	end

	// a stalled output transaction holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_data) && $stable(tx_dest)
			&& $stable(tx_last))
		else $error("tx changed while stalled");

	// a terminal byte is always the only result of its input byte
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_dest |-> tx_last)
		else $error("terminal byte without last");

	// a reply is sent without gaps once started
	a_reply_cont: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && tx_dest && !tx_last |=> tx_valid && tx_dest)
		else $error("reply interrupted");

	// every network reply opens with IAC
	a_reply_iac: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_dest && !mid_reply_q |-> tx_data == ByteIac)
		else $error("reply does not start with IAC");

	// input is never refused while nothing is queued or shown
	a_rx_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_valid && !$past(rx_valid && rx_ready) && !$past(tx_valid) |-> rx_ready)
		else $error("rx stalled while idle");

endmodule

bind telnet_option_responder_core tor_checker u_tor_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_valid (rx.valid),
	.rx_ready (rx.ready),
	.tx_valid (tx.valid),
	.tx_ready (tx.ready),
	.tx_dest  (tx.dest),
	.tx_data  (tx.data),
	.tx_last  (tx.last)
);
